### hw/rtl/hcj_pkg.sv
// Shared types, constants and helpers for the HSV color jitter unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hcj_pkg;

    localparam int COMP_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int HUE_W    = 15;
    localparam int SCALED_W = 20;
    localparam int PROD_W   = 27;
    localparam int CFG_IDX_W = 2;

    localparam logic [COMP_W-1:0] ONE_VAL = COMP_W'(1 << (COMP_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_SHIFT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_GAIN   = 2'd2;

    // Reciprocal of six, exact for dividends below 2^19.
    localparam logic [17:0] RECIP_SIX = 18'd174763;

    typedef enum logic [2:0] {
        SEC_RED_TO_YELLOW   = 3'd0,
        SEC_YELLOW_TO_GREEN = 3'd1,
        SEC_GREEN_TO_CYAN   = 3'd2,
        SEC_CYAN_TO_BLUE    = 3'd3,
        SEC_BLUE_TO_MAGENTA = 3'd4,
        SEC_MAGENTA_TO_RED  = 3'd5
    } hcj_sector_t;

    typedef struct packed {
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] delta;
        logic [COMP_W-1:0] num_abs;
        logic              num_neg;
        logic [2:0]        base;
        logic              hue_zero;
        logic              last;
    } hcj_cls_t;

    function automatic logic [COMP_W-1:0] clamp_unit(input logic signed [PROD_W-1:0] x);
        logic [COMP_W-1:0] res;
        if (x < 0)
        begin
            res = '0;
        end
        else if (x > $signed(PROD_W'(ONE_VAL)))
        begin
            res = ONE_VAL;
        end
        else
        begin
            res = x[COMP_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/hcj_front.sv
// Front end: finds max, min and delta of a pixel and picks the hue sector numerator.
// Depends on hcj_pkg.
`timescale 1ns / 1ps

module hcj_front
    import hcj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    input  logic              last,
    output logic              cls_valid,
    input  logic              cls_ready,
    output hcj_cls_t          cls
);

    logic               vld_reg;
    hcj_cls_t           cls_reg;
    hcj_cls_t           cls_next;
    logic [COMP_W-1:0]  mx;
    logic [COMP_W-1:0]  mn;
    logic signed [COMP_W:0] num;

    assign in_ready  = !vld_reg || cls_ready;
    assign cls_valid = vld_reg;
    assign cls       = cls_reg;

    always_comb
    begin
        mx = (red > green) ? ((red > blue) ? red : blue) : ((green > blue) ? green : blue);
        mn = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
        if (red == mx)
        begin
            num           = $signed({1'b0, green}) - $signed({1'b0, blue});
            cls_next.base = 3'd0;
        end
        else if (green == mx)
        begin
            num           = $signed({1'b0, blue}) - $signed({1'b0, red});
            cls_next.base = 3'd2;
        end
        else
        begin
            num           = $signed({1'b0, red}) - $signed({1'b0, green});
            cls_next.base = 3'd4;
        end
        cls_next.mx       = mx;
        cls_next.delta    = mx - mn;
        cls_next.num_neg  = num[COMP_W];
        cls_next.num_abs  = num[COMP_W] ? COMP_W'(-num) : num[COMP_W-1:0];
        cls_next.hue_zero = (mx == mn);
        cls_next.last     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

### hw/rtl/hcj_queue.sv
// Small FIFO that decouples the front end from the back end.
// Depends on hcj_pkg for the item type.
`timescale 1ns / 1ps

module hcj_queue
    import hcj_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  hcj_cls_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output hcj_cls_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hcj_cls_t        mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/hcj_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for a*2^15/b with a <= b.
// Depends on hcj_pkg for the component width.
`timescale 1ns / 1ps

module hcj_divider
    import hcj_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [COMP_W-1:0] a,
    input  logic [COMP_W-1:0] b,
    input  logic [SIDE_W-1:0] side_in,
    output logic [COMP_W-1:0] quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STEPS = COMP_W;

    logic [COMP_W-1:0] rem_reg  [STEPS];
    logic [COMP_W-1:0] quo_reg  [STEPS];
    logic [COMP_W-1:0] div_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic [COMP_W-1:0] rem_prev;
            logic [COMP_W-1:0] quo_prev;
            logic [COMP_W-1:0] div_prev;
            logic [SIDE_W-1:0] side_prev;
            logic              bit_in;
            logic [COMP_W:0]   trial;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign rem_prev  = {1'b0, a[COMP_W-1:1]};
                assign quo_prev  = '0;
                assign div_prev  = b;
                assign side_prev = side_in;
                assign bit_in    = a[0];
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign quo_prev  = quo_reg[k-1];
                assign div_prev  = div_reg[k-1];
                assign side_prev = side_reg[k-1];
                assign bit_in    = 1'b0;
            end

            assign trial = {rem_prev, bit_in};
            assign ge    = (trial >= {1'b0, div_prev});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[k] <= '0;
                end
                else if (en)
                begin
                    side_reg[k] <= side_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? COMP_W'(trial - {1'b0, div_prev}) : trial[COMP_W-1:0];
                    quo_reg[k] <= {quo_prev[COMP_W-2:0], ge};
                    div_reg[k] <= div_prev;
                end
            end
        end
    endgenerate

    assign quo      = quo_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];

endmodule

### hw/rtl/hcj_back.sv
// Back end: saturation and hue division, gains, hue shift and six-sector reconstruction.
// Depends on hcj_pkg and hcj_divider.
`timescale 1ns / 1ps

module hcj_back
    import hcj_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cls_valid,
    output logic                     cls_ready,
    input  hcj_cls_t                 cls,
    input  logic signed [GAIN_W-1:0] hue_shift,
    input  logic [GAIN_W-1:0]        saturation_gain,
    input  logic [GAIN_W-1:0]        exposure_gain,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COMP_W-1:0]        red,
    output logic [COMP_W-1:0]        green,
    output logic [COMP_W-1:0]        blue,
    output logic                     last
);

    localparam int SIDE_S = COMP_W + 2;
    localparam int SIDE_H = 5;

    logic en;
    logic [COMP_W-1:0] quo_s, quo_h;
    logic [SIDE_S-1:0] side_s;
    logic [SIDE_H-1:0] side_h;

    logic [4:0] vld_reg;
    logic [4:0] last_reg;

    // Stage 1
    logic [17:0]       hs_reg, hs_next;
    logic [COMP_W-1:0] s_reg, mx_reg;
    logic signed [18:0] hs_raw;
    // Stage 2
    logic [HUE_W-1:0]    hue_reg;
    logic [SCALED_W-1:0] sg_reg, vg_reg;
    logic [35:0]         hue_prod;
    logic [31:0]         s_prod, v_prod;
    // Stage 3
    logic signed [17:0]  hue_sum;
    logic [HUE_W-1:0]    hue_next;
    logic [17:0]         h6;
    logic [2:0]          sec3_reg;
    logic [HUE_W-1:0]    f_reg;
    logic [SCALED_W-1:0] sg3_reg, vg3_reg;
    // Stage 4
    logic [SCALED_W-1:0] sf_reg, st_reg, sg4_reg, vg4_reg;
    logic [2:0]          sec4_reg;
    logic [34:0]         sf_prod;
    logic [35:0]         st_prod;
    // Stage 5
    logic signed [SCALED_W:0]   one_s;
    logic signed [SCALED_W:0]   dp, dq, dt;
    logic signed [2*SCALED_W+1:0] pp, pq, pt;
    logic signed [PROD_W-1:0]   p_reg, q_reg, t_reg, v5_reg;
    logic [2:0]                 sec5_reg;
    // Output stage
    logic                vld_out_reg;
    logic                last_out_reg;
    logic [COMP_W-1:0]   r_reg, g_reg, b_reg;
    logic [COMP_W-1:0]   cp, cq, ct, cv;
    logic [COMP_W-1:0]   r_next, g_next, b_next;

    assign en        = !vld_out_reg || out_ready;
    assign cls_ready = en;

    hcj_divider #(.SIDE_W(SIDE_S)) u_div_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .a        (cls.delta),
        .b        (cls.mx),
        .side_in  ({cls_valid, cls.last, cls.mx}),
        .quo      (quo_s),
        .side_out (side_s)
    );

    hcj_divider #(.SIDE_W(SIDE_H)) u_div_hue (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .a        (cls.num_abs),
        .b        (cls.delta),
        .side_in  ({cls.num_neg, cls.base, cls.hue_zero}),
        .quo      (quo_h),
        .side_out (side_h)
    );

    always_comb
    begin
        hs_raw = $signed({1'b0, side_h[3:1], 15'd0});
        if (side_h[4])
        begin
            hs_raw = hs_raw - $signed({3'b0, quo_h});
        end
        else
        begin
            hs_raw = hs_raw + $signed({3'b0, quo_h});
        end
        if (hs_raw < 0)
        begin
            hs_raw = hs_raw + 19'sd196608;
        end
        hs_next = side_h[0] ? 18'd0 : hs_raw[17:0];

        hue_prod = hs_reg * RECIP_SIX;
        s_prod   = s_reg * saturation_gain;
        v_prod   = mx_reg * exposure_gain;

        hue_sum = $signed({3'b0, hue_reg}) + 18'(hue_shift);
        if (hue_sum >= 18'sd32768)
        begin
            hue_sum = hue_sum - 18'sd32768;
        end
        if (hue_sum < 0)
        begin
            hue_sum = hue_sum + 18'sd32768;
        end
        hue_next = hue_sum[HUE_W-1:0];
        h6       = ({3'b0, hue_next} << 2) + ({3'b0, hue_next} << 1);

        sf_prod = sg3_reg * f_reg;
        st_prod = sg3_reg * (16'd32768 - {1'b0, f_reg});

        one_s = $signed((SCALED_W+1)'(ONE_VAL));
        dp    = one_s - $signed({1'b0, sg4_reg});
        dq    = one_s - $signed({1'b0, sf_reg});
        dt    = one_s - $signed({1'b0, st_reg});
        pp    = $signed({1'b0, vg4_reg}) * dp;
        pq    = $signed({1'b0, vg4_reg}) * dq;
        pt    = $signed({1'b0, vg4_reg}) * dt;

        cp = clamp_unit(p_reg);
        cq = clamp_unit(q_reg);
        ct = clamp_unit(t_reg);
        cv = clamp_unit(v5_reg);
        unique case (hcj_sector_t'(sec5_reg))
            SEC_RED_TO_YELLOW:
            begin
                r_next = cv; g_next = ct; b_next = cp;
            end
            SEC_YELLOW_TO_GREEN:
            begin
                r_next = cq; g_next = cv; b_next = cp;
            end
            SEC_GREEN_TO_CYAN:
            begin
                r_next = cp; g_next = cv; b_next = ct;
            end
            SEC_CYAN_TO_BLUE:
            begin
                r_next = cp; g_next = cq; b_next = cv;
            end
            SEC_BLUE_TO_MAGENTA:
            begin
                r_next = ct; g_next = cp; b_next = cv;
            end
            default:
            begin
                r_next = cv; g_next = cp; b_next = cq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[3:0], side_s[SIDE_S-1]};
            vld_out_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg     <= {last_reg[3:0], side_s[SIDE_S-2]};
            last_out_reg <= last_reg[4];

            hs_reg <= hs_next;
            s_reg  <= (side_s[COMP_W-1:0] == '0) ? '0 : quo_s;
            mx_reg <= side_s[COMP_W-1:0];

            hue_reg <= hue_prod[20 +: HUE_W];
            sg_reg  <= s_prod[12 +: SCALED_W];
            vg_reg  <= v_prod[12 +: SCALED_W];

            sec3_reg <= h6[17:15];
            f_reg    <= h6[HUE_W-1:0];
            sg3_reg  <= sg_reg;
            vg3_reg  <= vg_reg;

            sf_reg   <= sf_prod[15 +: SCALED_W];
            st_reg   <= st_prod[15 +: SCALED_W];
            sg4_reg  <= sg3_reg;
            vg4_reg  <= vg3_reg;
            sec4_reg <= sec3_reg;

            p_reg    <= pp[15 +: PROD_W];
            q_reg    <= pq[15 +: PROD_W];
            t_reg    <= pt[15 +: PROD_W];
            v5_reg   <= $signed({(PROD_W-SCALED_W)'(0), vg4_reg});
            sec5_reg <= sec4_reg;

            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign out_valid = vld_out_reg;
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;
    assign last      = last_out_reg;

endmodule

### hw/rtl/hsv_color_jitter_unit.sv
// Top level of the HSV color jitter unit: configuration registers, front end, queue, back end.
// Depends on hcj_pkg, hcj_front, hcj_queue and hcj_back.
//
//  channel   direction  signals                          payload
//  s_axis    in         s_tvalid s_tready s_tdata s_tlast red, green, blue; last
//  m_axis    out        m_tvalid m_tready m_tdata m_tlast red, green, blue; last
//  config    in         cfg_we cfg_index cfg_data       hue shift, saturation/exposure gains
//
// One item per cycle is accepted when nothing stalls. The path runs through one front
// stage, the queue, 16 divider stages (one quotient bit each) and six arithmetic stages.
// Reset clears valid state and loads the register defaults; no clearing pass is needed.
// A stall on m_tready freezes the back end while the queue accepts items until it is full.
`timescale 1ns / 1ps

module hsv_color_jitter_unit
    import hcj_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*COMP_W-1:0]   s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*COMP_W-1:0]   m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0]     cfg_data
);

    logic [GAIN_W-1:0] hue_shift_reg;
    logic [GAIN_W-1:0] sat_gain_reg;
    logic [GAIN_W-1:0] exp_gain_reg;

    logic     f_valid, f_ready, q_valid, q_ready;
    hcj_cls_t f_cls, q_cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg <= '0;
            sat_gain_reg  <= 16'd4096;
            exp_gain_reg  <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HUE_SHIFT:       hue_shift_reg <= cfg_data;
                CFG_SATURATION_GAIN: sat_gain_reg  <= cfg_data;
                CFG_EXPOSURE_GAIN:   exp_gain_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    hcj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[COMP_W-1:0]),
        .green     (s_tdata[2*COMP_W-1:COMP_W]),
        .blue      (s_tdata[3*COMP_W-1:2*COMP_W]),
        .last      (s_tlast),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls       (f_cls)
    );

    hcj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cls)
    );

    hcj_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cls_valid       (q_valid),
        .cls_ready       (q_ready),
        .cls             (q_cls),
        .hue_shift       ($signed(hue_shift_reg)),
        .saturation_gain (sat_gain_reg),
        .exposure_gain   (exp_gain_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .red             (m_tdata[COMP_W-1:0]),
        .green           (m_tdata[2*COMP_W-1:COMP_W]),
        .blue            (m_tdata[3*COMP_W-1:2*COMP_W]),
        .last            (m_tlast)
    );

endmodule

### tb/hsv_color_jitter_unit_tb.sv
// Self-checking testbench for the HSV color jitter unit: directed and random pixels
// under random idling on both stream sides, checked against an in-bench HSV model.
// Depends on hcj_pkg and hsv_color_jitter_unit.
`timescale 1ns / 1ps

module hsv_color_jitter_unit_tb;
    import hcj_pkg::*;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              last;
    } pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [3*COMP_W-1:0]  s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [3*COMP_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    logic signed [63:0] hue_shift_q;
    logic signed [63:0] sat_gain_q;
    logic signed [63:0] exp_gain_q;

    pixel_t expected_pixels[$];
    int     mismatches;
    int     pixels_sent;
    int     pixels_checked;
    int     idle_cycles;
    int     hold_cycles;
    bit     sink_pause;

    hsv_color_jitter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [63:0] clamp_component(input logic signed [63:0] x);
        if (x < 0)
        begin
            return 0;
        end
        if (x > 32768)
        begin
            return 32768;
        end
        return x;
    endfunction

    function automatic pixel_t jitter_pixel(input pixel_t px);
        logic signed [63:0] r, g, b, mx, mn, delta, sat, val, hue, hs, h6, f, p, q, t;
        logic signed [63:0] ro, go, bo;
        pixel_t res;
        r = 64'(px.red);
        g = 64'(px.green);
        b = 64'(px.blue);
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        delta = mx - mn;
        val = mx;
        sat = 0;
        hue = 0;
        if (mx != 0)
        begin
            sat = (delta * 32768) / mx;
            if (delta != 0)
            begin
                if (r == mx)
                begin
                    hs = ((g - b) * 32768) / delta;
                end
                else if (g == mx)
                begin
                    hs = 2 * 32768 + ((b - r) * 32768) / delta;
                end
                else
                begin
                    hs = 4 * 32768 + ((r - g) * 32768) / delta;
                end
                if (hs < 0)
                begin
                    hs = hs + 6 * 32768;
                end
                hue = hs / 6;
            end
        end
        sat = (sat * sat_gain_q) >>> 12;
        val = (val * exp_gain_q) >>> 12;
        hue = hue + hue_shift_q;
        if (hue >= 32768)
        begin
            hue = hue - 32768;
        end
        if (hue < 0)
        begin
            hue = hue + 32768;
        end
        if (sat == 0)
        begin
            ro = val;
            go = val;
            bo = val;
        end
        else
        begin
            h6 = hue * 6;
            f = h6 & 32767;
            p = (val * (32768 - sat)) / 32768;
            q = (val * (32768 - ((sat * f) >>> 15))) / 32768;
            t = (val * (32768 - ((sat * (32768 - f)) >>> 15))) / 32768;
            case (hcj_sector_t'(h6 >>> 15))
                SEC_RED_TO_YELLOW:   begin ro = val; go = t;   bo = p;   end
                SEC_YELLOW_TO_GREEN: begin ro = q;   go = val; bo = p;   end
                SEC_GREEN_TO_CYAN:   begin ro = p;   go = val; bo = t;   end
                SEC_CYAN_TO_BLUE:    begin ro = p;   go = q;   bo = val; end
                SEC_BLUE_TO_MAGENTA: begin ro = t;   go = p;   bo = val; end
                default:             begin ro = val; go = p;   bo = q;   end
            endcase
        end
        res.red = 16'(clamp_component(ro));
        res.green = 16'(clamp_component(go));
        res.blue = 16'(clamp_component(bo));
        res.last = px.last;
        return res;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HUE_SHIFT)
        begin
            hue_shift_q = 64'($signed(value));
        end
        else if (idx == CFG_SATURATION_GAIN)
        begin
            sat_gain_q = 64'(value);
        end
        else if (idx == CFG_EXPOSURE_GAIN)
        begin
            exp_gain_q = 64'(value);
        end
    endtask

    task automatic set_gains(input logic [15:0] shift, input logic [15:0] sat,
                             input logic [15:0] expo);
        write_register(CFG_HUE_SHIFT, shift);
        write_register(CFG_SATURATION_GAIN, sat);
        write_register(CFG_EXPOSURE_GAIN, expo);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_pixel(input pixel_t px, input bit use_gaps);
        int gap;
        gap = use_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {px.blue, px.green, px.red};
        s_tlast <= px.last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        expected_pixels.push_back(jitter_pixel(px));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [15:0] random_component();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.red = random_component();
        px.green = random_component();
        px.blue = random_component();
        if ($urandom_range(0, 5) == 0)
        begin
            px.green = px.red;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            px.blue = px.red;
        end
        px.last = ($urandom_range(0, 15) == 0);
        return px;
    endfunction

    task automatic test_directed_pixels();
        pixel_t list[$];
        list.push_back('{16'd0, 16'd0, 16'd0, 1'b0});
        list.push_back('{16'd32768, 16'd32768, 16'd32768, 1'b1});
        list.push_back('{16'd12000, 16'd12000, 16'd12000, 1'b0});
        list.push_back('{16'd32768, 16'd0, 16'd0, 1'b0});
        list.push_back('{16'd32768, 16'd32768, 16'd0, 1'b0});
        list.push_back('{16'd0, 16'd32768, 16'd0, 1'b0});
        list.push_back('{16'd0, 16'd32768, 16'd32768, 1'b0});
        list.push_back('{16'd0, 16'd0, 16'd32768, 1'b0});
        list.push_back('{16'd32768, 16'd0, 16'd32768, 1'b1});
        list.push_back('{16'd30000, 16'd1000, 16'd20000, 1'b0});
        list.push_back('{16'd65535, 16'd65535, 16'd65535, 1'b1});
        list.push_back('{16'd65535, 16'd0, 16'd40000, 1'b0});
        list.push_back('{16'd1, 16'd0, 16'd0, 1'b0});
        list.push_back('{16'd5, 16'd10, 16'd32767, 1'b1});
        foreach (list[i])
        begin
            send_pixel(list[i], 1'b0);
        end
        stop_sending();
        wait_drained();
    endtask

    task automatic test_register_settings();
        logic [15:0] shifts[5] = '{16'hC000, 16'h4000, 16'h0000, 16'h7FFF, 16'h8000};
        logic [15:0] gains[5] = '{16'd0, 16'd65535, 16'd4096, 16'd8192, 16'd2048};
        for (int k = 0; k < 5; k++)
        begin
            set_gains(shifts[k], gains[k], gains[4 - k]);
            for (int i = 0; i < 40; i++)
            begin
                send_pixel(random_pixel(), 1'b1);
            end
            stop_sending();
            wait_drained();
        end
        // An index past the register list must leave every register alone.
        write_register(2'd3, 16'h1234);
    endtask

    task automatic test_random_pixels();
        for (int k = 0; k < 10; k++)
        begin
            set_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 1) == 0)
            begin
                set_gains(16'($signed($urandom_range(0, 32768)) - 16384),
                          16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)));
            end
            for (int i = 0; i < 100; i++)
            begin
                send_pixel(random_pixel(), (i / 25) % 2 == 1);
            end
            stop_sending();
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        set_gains(16'h1000, 16'd6000, 16'd5000);
        hold_cycles = 60;
        for (int i = 0; i < 100; i++)
        begin
            send_pixel(random_pixel(), 1'b0);
        end
        stop_sending();
        wait_drained();
    endtask

    // Receiver: random stalls per item, and a long hold-off when requested.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        sink_pause = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            stall = sink_pause ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                do
                begin
                    @(posedge clk);
                end
                while (!m_tvalid);
                if (($urandom_range(0, 99)) < 2)
                begin
                    sink_pause = !sink_pause;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red = m_tdata[COMP_W-1:0];
            got.green = m_tdata[2*COMP_W-1:COMP_W];
            got.blue = m_tdata[3*COMP_W-1:2*COMP_W];
            got.last = m_tlast;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected output item rgb=%0d,%0d,%0d last=%0b",
                             got.red, got.green, got.blue, got.last);
                end
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch item %0d: expected rgb=%0d,%0d,%0d last=%0b",
                                 pixels_checked, want.red, want.green, want.blue, want.last);
                        $display("                 actual   rgb=%0d,%0d,%0d last=%0b",
                                 got.red, got.green, got.blue, got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 5000)
        begin
            $display("Timeout: no item moved for 5000 cycles");
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hue_shift_q = 0;
        sat_gain_q = 4096;
        exp_gain_q = 4096;
        mismatches = 0;
        pixels_sent = 0;
        pixels_checked = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_pixels();
        test_register_settings();
        test_random_pixels();
        test_output_backpressure();
        wait_drained();
        if (expected_pixels.size() != 0)
        begin
            mismatches++;
        end
        $display("Covered %0d pixels (%0d checked) over gain, hue and stall settings.",
                 pixels_sent, pixels_checked);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("Mismatches: %0d", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/hcj_pkg.sv
hw/rtl/hcj_front.sv
hw/rtl/hcj_queue.sv
hw/rtl/hcj_divider.sv
hw/rtl/hcj_back.sv
hw/rtl/hsv_color_jitter_unit.sv
tb/hsv_color_jitter_unit_tb.sv
